FILE: src/gcb_pkg.sv
// ----------------------------------------------------------------------------
// gcb_pkg: shared constants, types and tables
// Fixed-point constants, register indexes and elaboration-time tables for the
// gamma / contrast / brightness ramp pipeline.
// ----------------------------------------------------------------------------
package gcb_pkg;

  localparam int CODE_BITS = 8;
  localparam int CODE_MAX  = (1 << CODE_BITS) - 1;
  localparam int IN_W      = ((CODE_BITS + 7) / 8) * 8;
  localparam int LVL_W     = 16;

  // Log distance is below (CODE_BITS + 1) * 2^16, so 20 bits cover every size.
  localparam int LOG_W      = 20;
  localparam int NUM_W      = 32;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = NUM_W / DIV_BITS;
  localparam int EXP_STEPS  = 16;

  localparam logic [15:0] GAMMA_MIN = 16'd410;
  localparam logic [15:0] UNITY_PCT = 16'd25600;
  localparam logic [15:0] LEVEL_SCALE = 16'(CODE_MAX << (16 - CODE_BITS));

  // x / 25 == (x * DIV25_K) >> DIV25_SHIFT, exact for x below 2^22.
  localparam logic [21:0] DIV25_K     = 22'd2684355;
  localparam int          DIV25_SHIFT = 26;

  localparam logic [1:0] REG_GAMMA      = 2'd0;
  localparam logic [1:0] REG_CONTRAST   = 2'd1;
  localparam logic [1:0] REG_BRIGHTNESS = 2'd2;

  typedef logic [LOG_W-1:0] dist_t;
  typedef dist_t dist_table_t [0:CODE_MAX];
  typedef logic [31:0] root_table_t [1:EXP_STEPS];

  // log2 of x (x >= 1) in Q.16, by repeated squaring of the mantissa.
  function automatic logic [63:0] log2_q16(input logic [31:0] x);
    int          n;
    logic [63:0] m;
    logic [15:0] frac;
    n = 0;
    while (n < 31 && (x >> (n + 1)) != 0) n++;
    m = 64'(x) << (30 - n);
    frac = '0;
    for (int k = 0; k < 16; k++) begin
      m = (m * m) >> 30;
      frac = {frac[14:0], 1'b0};
      if (m >= (64'd1 << 31)) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return (64'(n) << 16) | 64'(frac);
  endfunction

  function automatic dist_table_t make_dist_table();
    dist_table_t tbl;
    logic [63:0] lm;
    logic [63:0] lc;
    lm = log2_q16(32'(CODE_MAX));
    tbl[0] = '0;
    for (int c = 1; c <= CODE_MAX; c++) begin
      lc = log2_q16(32'(c));
      tbl[c] = (lc > lm) ? '0 : LOG_W'(lm - lc);
    end
    return tbl;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] a_in);
    logic [63:0] a;
    logic [63:0] r;
    logic [63:0] b;
    a = a_in;
    r = '0;
    b = 64'd1 << 62;
    while (b > a) b = b >> 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Factors 2^(-2^-k) in Q0.32.
  function automatic root_table_t make_roots();
    root_table_t rt;
    logic [63:0] prev;
    prev = 64'd1 << 31;
    for (int k = 1; k <= EXP_STEPS; k++) begin
      prev = isqrt64(prev << 32);
      rt[k] = prev[31:0];
    end
    return rt;
  endfunction

  localparam dist_table_t DIST_TABLE = make_dist_table();
  localparam root_table_t ROOTS      = make_roots();

endpackage

FILE: src/gcb_div_stage.sv
// ----------------------------------------------------------------------------
// gcb_div_stage: one registered slice of the exponent divider
// Restoring division, DIV_BITS quotient bits per stage.
// ----------------------------------------------------------------------------
module gcb_div_stage
  import gcb_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [15:0]      divisor,
  input  logic [15:0]      rem_in,
  input  logic [NUM_W-1:0] num_in,
  input  logic [NUM_W-1:0] quo_in,
  output logic [15:0]      rem_out,
  output logic [NUM_W-1:0] num_out,
  output logic [NUM_W-1:0] quo_out
);

  logic [15:0]      rem_next;
  logic [NUM_W-1:0] num_next;
  logic [NUM_W-1:0] quo_next;
  logic [16:0]      trial;

  always_comb begin
    rem_next = rem_in;
    num_next = num_in;
    quo_next = quo_in;
    trial    = '0;
    for (int s = 0; s < DIV_BITS; s++) begin
      trial    = {rem_next, num_next[NUM_W-1]};
      num_next = {num_next[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_next = 16'(trial - {1'b0, divisor});
        quo_next = {quo_next[NUM_W-2:0], 1'b1};
      end else begin
        rem_next = trial[15:0];
        quo_next = {quo_next[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= rem_next;
      num_out <= num_next;
      quo_out <= quo_next;
    end
  end

endmodule

FILE: src/gcb_exp_stage.sv
// ----------------------------------------------------------------------------
// gcb_exp_stage: one factor of the 2^-t product
// Multiplies the running Q0.32 product by one root when its bit is set.
// ----------------------------------------------------------------------------
module gcb_exp_stage (
  input  logic        clk,
  input  logic        en,
  input  logic        sel,
  input  logic [31:0] root,
  input  logic [31:0] p_in,
  input  logic        one_in,
  output logic [31:0] p_out,
  output logic        one_out
);

  logic [63:0] prod;

  // While the product is still exactly one, it is held only as a flag.
  assign prod = 64'(p_in) * 64'(root);

  always_ff @(posedge clk) begin
    if (en) begin
      if (sel) begin
        p_out   <= one_in ? root : prod[63:32];
        one_out <= 1'b0;
      end else begin
        p_out   <= p_in;
        one_out <= one_in;
      end
    end
  end

endmodule

FILE: src/gcb_post.sv
// ----------------------------------------------------------------------------
// gcb_post: contrast, brightness, clamp and level scaling
// Four register stages from the Q.16 power value to the output level.
// ----------------------------------------------------------------------------
module gcb_post
  import gcb_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic [16:0]          pwr,
  input  logic [CODE_BITS-1:0] code,
  input  logic [15:0]          contrast,
  input  logic [15:0]          brightness,
  output logic [LVL_W-1:0]     level
);

  logic signed [17:0] cen;
  logic signed [34:0] cprod;
  logic signed [34:0] c_prod_r;
  logic [CODE_BITS-1:0] code1, code2, code3;

  logic [33:0] c_mag;
  logic [20:0] c_a;
  logic signed [16:0] b_diff;
  logic [21:0] b_mag;
  logic [42:0] c_m_r, b_m_r;
  logic        c_neg_r, b_neg_r;

  logic [16:0] c_q, b_q;
  logic signed [19:0] w;
  logic [16:0] w_r;

  logic [32:0] lprod;
  logic [17:0] lsum;

  // Stage 1: centered power times contrast.
  assign cen   = $signed({1'b0, pwr}) - 18'sd32768;
  assign cprod = 35'(cen) * 35'($signed({1'b0, contrast}));

  always_ff @(posedge clk) begin
    if (en) begin
      c_prod_r <= cprod;
      code1    <= code;
    end
  end

  // Stage 2: divide by 25600 as a shift and a reciprocal multiply, on magnitudes.
  assign c_mag  = c_prod_r[34] ? 34'(-c_prod_r) : c_prod_r[33:0];
  assign c_a    = c_mag[30:10];
  assign b_diff = $signed({1'b0, brightness}) - $signed({1'b0, UNITY_PCT});
  assign b_mag  = b_diff[16] ? {16'(-b_diff), 6'd0} : {b_diff[15:0], 6'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      c_m_r   <= 43'(c_a) * 43'(DIV25_K);
      b_m_r   <= 43'(b_mag) * 43'(DIV25_K);
      c_neg_r <= c_prod_r[34];
      b_neg_r <= b_diff[16];
      code2   <= code1;
    end
  end

  // Stage 3: restore signs, add offsets and clamp to [0, 1].
  assign c_q = c_m_r[DIV25_SHIFT+16:DIV25_SHIFT];
  assign b_q = b_m_r[DIV25_SHIFT+16:DIV25_SHIFT];
  assign w   = (c_neg_r ? -$signed({3'b0, c_q}) : $signed({3'b0, c_q}))
             + (b_neg_r ? -$signed({3'b0, b_q}) : $signed({3'b0, b_q}))
             + 20'sd32768;

  always_ff @(posedge clk) begin
    if (en) begin
      if (w < 0) begin
        w_r <= '0;
      end else if (w > 20'sd65536) begin
        w_r <= 17'd65536;
      end else begin
        w_r <= w[16:0];
      end
      code3 <= code2;
    end
  end

  // Stage 4: scale to the output range and add the code back.
  assign lprod = 33'(w_r) * 33'(LEVEL_SCALE);
  assign lsum  = {1'b0, lprod[32:16]} + 18'(code3);

  always_ff @(posedge clk) begin
    if (en) begin
      level <= (lsum > 18'hFFFF) ? 16'hFFFF : lsum[15:0];
    end
  end

endmodule

FILE: src/gamma_contrast_brightness_ramp.sv
// ----------------------------------------------------------------------------
// gamma_contrast_brightness_ramp: pixel code to corrected 16-bit level
// Gamma power law, contrast stretch about one half, brightness shift, clamp.
// ----------------------------------------------------------------------------
// Usage: pixel codes enter on the s_axis stream, one transaction per pixel,
// and each gives exactly one corrected level on the m_axis stream, in order.
// The three settings are written through cfg_we / cfg_index / cfg_data; a
// write to index 3 is ignored. Write them only while no pixel is in flight.
//
// The pipeline is 30 register stages deep: a log-distance table lookup, eight
// divider stages (four quotient bits each, dividing by the gamma setting),
// sixteen multiplier stages forming 2^-t one root factor at a time, a shift
// stage, and four stages for contrast, brightness, clamp and level scaling.
// Throughput is one pixel per clock while no result is stalled at the output,
// since every stage then takes a new item each cycle.
//
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready drops in that same cycle, so nothing is lost or repeated.
// Bubbles are not squeezed out, so a blocked result always blocks the input.
// Reset empties the pipeline and loads gamma 1.0, contrast 100% and
// brightness 100%.
// ----------------------------------------------------------------------------
module gamma_contrast_brightness_ramp
  import gcb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // [CODE_BITS-1:0] pixel_code
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [LVL_W-1:0] m_axis_tdata,   // [15:0] ramp_level
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data
);

  localparam int EXP_FIRST = 1 + DIV_STAGES;
  localparam int SHIFT_ST  = EXP_FIRST + EXP_STEPS;
  localparam int NST       = SHIFT_ST + 1 + 4;

  logic [15:0] gamma_setting;
  logic [15:0] contrast_percent;
  logic [15:0] brightness_percent;
  logic [15:0] gamma_eff;

  logic           en;
  logic [NST-1:0] vld;

  logic [CODE_BITS-1:0] in_code;
  logic [CODE_BITS-1:0] code_p [0:SHIFT_ST];
  logic                 nz_p   [0:SHIFT_ST];
  dist_t                dist_r;

  logic [15:0]      rem_a [0:DIV_STAGES];
  logic [NUM_W-1:0] num_a [0:DIV_STAGES];
  logic [NUM_W-1:0] quo_a [0:DIV_STAGES];

  logic [NUM_W-1:0] q_x   [0:EXP_STEPS];
  logic [31:0]      p_x   [0:EXP_STEPS];
  logic             one_x [0:EXP_STEPS];

  logic [15:0] ip;
  logic [32:0] shifted;
  logic [16:0] pwr_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_setting      <= 16'd4096;
      contrast_percent   <= UNITY_PCT;
      brightness_percent <= UNITY_PCT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAMMA:      gamma_setting      <= cfg_data;
        REG_CONTRAST:   contrast_percent   <= cfg_data;
        REG_BRIGHTNESS: brightness_percent <= cfg_data;
        default: ;
      endcase
    end
  end

  assign gamma_eff = (gamma_setting < GAMMA_MIN) ? GAMMA_MIN : gamma_setting;

  // The whole pipeline advances together unless a finished result is stuck.
  assign en            = !vld[NST-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], s_axis_tvalid};
    end
  end

  // Stage 0: log-distance lookup. Upper code bits are ignored.
  assign in_code = s_axis_tdata[CODE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r    <= DIST_TABLE[in_code];
      code_p[0] <= in_code;
      nz_p[0]   <= (in_code != '0);
    end
  end

  for (genvar i = 1; i <= SHIFT_ST; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        code_p[i] <= code_p[i-1];
        nz_p[i]   <= nz_p[i-1];
      end
    end
  end

  // Divider: t = floor(d * 4096 / gamma).
  assign rem_a[0] = '0;
  assign num_a[0] = NUM_W'(dist_r) << 12;
  assign quo_a[0] = '0;

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    gcb_div_stage u_div (
      .clk     (clk),
      .en      (en),
      .divisor (gamma_eff),
      .rem_in  (rem_a[i]),
      .num_in  (num_a[i]),
      .quo_in  (quo_a[i]),
      .rem_out (rem_a[i+1]),
      .num_out (num_a[i+1]),
      .quo_out (quo_a[i+1])
    );
  end

  // Fraction bits of t choose root factors, most significant first.
  assign q_x[0]   = quo_a[DIV_STAGES];
  assign p_x[0]   = '0;
  assign one_x[0] = 1'b1;

  for (genvar j = 0; j < EXP_STEPS; j++) begin : g_exp
    gcb_exp_stage u_exp (
      .clk     (clk),
      .en      (en),
      .sel     (q_x[j][EXP_STEPS-1-j]),
      .root    (ROOTS[j+1]),
      .p_in    (p_x[j]),
      .one_in  (one_x[j]),
      .p_out   (p_x[j+1]),
      .one_out (one_x[j+1])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        q_x[j+1] <= q_x[j];
      end
    end
  end

  // Integer part of t shifts the product; a deep power or code zero gives 0.
  assign ip      = q_x[EXP_STEPS][31:16];
  assign shifted = {one_x[EXP_STEPS], p_x[EXP_STEPS]} >> ip[5:0];

  always_ff @(posedge clk) begin
    if (en) begin
      if (!nz_p[SHIFT_ST-1] || ip > 16'd32) begin
        pwr_r <= '0;
      end else begin
        pwr_r <= shifted[32:16];
      end
    end
  end

  gcb_post u_post (
    .clk        (clk),
    .en         (en),
    .pwr        (pwr_r),
    .code       (code_p[SHIFT_ST]),
    .contrast   (contrast_percent),
    .brightness (brightness_percent),
    .level      (m_axis_tdata)
  );

`ifndef NO_ASSERTIONS
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a blocked result");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(vld))
    else $error("pipeline moved during a stall");
`endif

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for gamma_contrast_brightness_ramp
// Pixel codes are streamed into the block under several gamma, contrast and
// brightness settings. An internal fixed-point predictor computes each
// expected level, and every output transaction is checked in order against it.
// ----------------------------------------------------------------------------
module tb_top;
  import gcb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 40;

  // Register index that maps to no setting.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic             clk;
  logic             rst;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;   // [7:0] pixel_code
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [LVL_W-1:0] m_axis_tdata;   // [15:0] ramp_level
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [15:0]      cfg_data;

  // Predictor copy of the three settings.
  logic [15:0] gamma_q;
  logic [15:0] contrast_q;
  logic [15:0] bright_q;

  logic [15:0] level_queue[$];
  int          error_count;
  int          levels_checked;
  int          idle_cycles;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_receiver;

  gamma_contrast_brightness_ramp uut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // log2 in Q.16 by repeated squaring of the Q2.30 mantissa.
  function automatic longint log2_fixed(input int unsigned x);
    int          top;
    logic [63:0] mant;
    logic [15:0] frac;
    top = 0;
    while (top < 31 && (x >> (top + 1)) != 0) top++;
    mant = 64'(x) << (30 - top);
    frac = '0;
    for (int k = 0; k < 16; k++) begin
      mant = (mant * mant) >> 30;
      frac = {frac[14:0], 1'b0};
      if (mant >= (64'd1 << 31)) begin
        frac[0] = 1'b1;
        mant = mant >> 1;
      end
    end
    return (longint'(top) << 16) | longint'(frac);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] val);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bitv;
    rem = val;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // 2^-t with t in Q.16, result in Q.16.
  function automatic longint pow2_neg(input logic [63:0] t);
    logic [63:0] root_k;
    logic [63:0] prod;
    logic [63:0] ipart;
    root_k = 64'd1 << 31;
    prod = 64'd1 << 32;
    ipart = t >> 16;
    for (int k = 1; k <= 16; k++) begin
      root_k = int_sqrt(root_k << 32);
      if (t[16 - k]) prod = (prod * root_k) >> 32;
    end
    if (ipart > 32) prod = 0;
    else prod = prod >> ipart;
    return longint'(prod >> 16);
  endfunction

  function automatic logic [15:0] predict_level(input logic [7:0] code);
    longint      g;
    longint      pw;
    longint      log_dist;
    longint      w;
    longint      lvl;
    logic [63:0] t;
    g = (gamma_q < GAMMA_MIN) ? longint'(GAMMA_MIN) : longint'(gamma_q);
    pw = 0;
    if (code != 0) begin
      log_dist = log2_fixed(CODE_MAX) - log2_fixed(code);
      if (log_dist < 0) log_dist = 0;
      t = 64'(log_dist * 4096) / 64'(g);
      pw = pow2_neg(t);
    end
    // SystemVerilog signed division truncates toward zero, as required.
    w = ((pw - 32768) * longint'(contrast_q)) / 25600 + 32768;
    w += ((longint'(bright_q) - 25600) * 256) / 100;
    if (w < 0) w = 0;
    if (w > 65536) w = 65536;
    lvl = ((w * longint'(LEVEL_SCALE)) >>> 16) + longint'(code);
    if (lvl > 65535) lvl = 65535;
    return lvl[15:0];
  endfunction

  // Register write; called only while the pipeline is empty.
  task automatic write_setting(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_GAMMA:      gamma_q = val;
      REG_CONTRAST:   contrast_q = val;
      REG_BRIGHTNESS: bright_q = val;
      default: ;
    endcase
  endtask

  // Offers one pixel code, with a random idle gap first, and waits for the
  // transaction. The expected level is queued at the accepting edge.
  task automatic send_code(input logic [7:0] code);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = code;
    do @(posedge clk); while (!s_axis_tready);
    level_queue.insert(level_queue.size(), predict_level(code));
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (level_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_all(input logic [15:0] g, input logic [15:0] c,
                         input logic [15:0] b);
    wait_drained();
    write_setting(REG_GAMMA, g);
    write_setting(REG_CONTRAST, c);
    write_setting(REG_BRIGHTNESS, b);
  endtask

  task automatic test_directed();
    logic [7:0] codes[8] = '{8'd0, 8'd1, 8'd2, 8'd127, 8'd128, 8'd170, 8'd254, 8'd255};
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (codes[i]) send_code(codes[i]);
    // Small gamma clamps to 0.1, which also drives dark codes into the
    // deep-power region where 2^-t vanishes.
    set_all(16'd0, 16'd25600, 16'd25600);
    foreach (codes[i]) send_code(codes[i]);
    // Opposite extremes: widest gamma, no contrast, full brightness.
    set_all(16'hFFFF, 16'd0, 16'hFFFF);
    send_code(8'd0);
    send_code(8'd255);
    // Maximum contrast, zero brightness pushes dark and mid codes against the lower clamp.
    set_all(16'd409, 16'hFFFF, 16'd0);
    send_code(8'd1);
    send_code(8'd128);
    send_code(8'd255);
    // Writes to the unused index must leave every setting unchanged.
    wait_drained();
    write_setting(REG_UNUSED, 16'h1234);
    send_code(8'd200);
    send_code(8'd55);
  endtask

  task automatic random_phase(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) send_code(8'($urandom));
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 12; ph++) begin
      set_all(16'($urandom_range(300, 24000)), 16'($urandom_range(0, 60000)),
              16'($urandom_range(12000, 40000)));
      case (ph % 4)
        0: random_phase(110, 0, 0);
        1: random_phase(110, 53, 0);
        2: random_phase(110, 0, 53);
        default: random_phase(110, 13, 13);
      endcase
    end
    // Fully random settings to reach every register bit.
    set_all(16'($urandom), 16'($urandom), 16'($urandom));
    random_phase(60, 13, 13);
  endtask

  // Long receiver hold-off so the pipeline fills and back-pressures the input,
  // then a sender pause until every level has come back.
  task automatic test_backpressure();
    set_all(16'd4096, 16'd25600, 16'd25600);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_receiver = 1'b1;
    for (int i = 0; i < 70; i++) send_code(8'($urandom));
    while (level_queue.size() != 0) @(negedge clk);
    random_phase(40, 0, 0);
  endtask

  // Releases the long receiver hold-off after a counted stretch.
  initial begin
    wait (hold_receiver);
    repeat (150) @(negedge clk);
    hold_receiver = 1'b0;
  end

  always @(negedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= !hold_receiver && ($urandom_range(99) >= recv_stall_pct);
  end

  // Output checker and watchdog on the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (level_queue.size() == 0) begin
          $error("unexpected ramp_level transaction: actual %0d", m_axis_tdata);
          error_count++;
        end else begin
          if (m_axis_tdata !== level_queue[0]) begin
            $error("ramp_level mismatch: expected %0d actual %0d",
                   level_queue[0], m_axis_tdata);
            error_count++;
          end
          void'(level_queue.pop_front());
          levels_checked++;
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    gamma_q = 16'd4096;
    contrast_q = 16'd25600;
    bright_q = 16'd25600;
    error_count = 0;
    levels_checked = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_receiver = 1'b0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random_settings();
    test_backpressure();

    while (level_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Checked %0d levels across directed extremes, random settings,",
             levels_checked);
    $display("random idling and stalls, and a full-pipeline back-pressure run.");
    if (error_count == 0 && level_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/gcb_pkg.sv
src/gcb_div_stage.sv
src/gcb_exp_stage.sv
src/gcb_post.sv
src/gamma_contrast_brightness_ramp.sv
test/tb_top.sv
